// ===== rtl/assert_macros.svh =====
// Assertion macros for the trie block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define AST_IMP(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define AST_NXT(lbl, clk, rst_n, a, c, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define AST_IMP(lbl, clk, rst_n, a, c, msg)
`define AST_NXT(lbl, clk, rst_n, a, c, msg)
`endif
`endif

// ===== rtl/mxt_pkg.sv =====
`timescale 1ns / 1ps
package mxt_pkg;
    localparam int NodeCountDef = 4096;
    localparam int KeyBitsDef   = 32;
    localparam int CountBitsDef = 20;

    localparam logic [1:0] OP_INS = 2'd0;
    localparam logic [1:0] OP_DEL = 2'd1;
    localparam logic [1:0] OP_QRY = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_ABSENT = 2'd2;
    localparam logic [1:0] ST_EMPTY  = 2'd3;
endpackage

// ===== rtl/mxt_node_mem.sv =====
`timescale 1ns / 1ps
// Node pool: two child links and a pass count per node, registered read port
module mxt_node_mem #(
    parameter int AW = 12,
    parameter int CW = 20
) (
    input  logic          i_clk,
    input  logic [AW-1:0] i_raddr,
    output logic [AW-1:0] o_c0,
    output logic [AW-1:0] o_c1,
    output logic [CW-1:0] o_cnt,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [AW-1:0] i_wc0,
    input  logic [AW-1:0] i_wc1,
    input  logic [CW-1:0] i_wcnt
);
    localparam int W = 2 * AW + CW;
    logic [W-1:0] mem [0:(1<<AW)-1];
    logic [W-1:0] r_rd;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= {i_wc0, i_wc1, i_wcnt};
        end
        r_rd <= mem[i_raddr];
    end

    assign o_c0  = r_rd[W-1 -: AW];
    assign o_c1  = r_rd[CW+AW-1 -: AW];
    assign o_cnt = r_rd[CW-1:0];
endmodule

// ===== rtl/max_xor_multiset_trie.sv =====
`timescale 1ns / 1ps
// Max-XOR multiset trie. Pulse start while busy is low with i_op and i_key;
// one result appears on o_max_xor/o_status for one cycle with o_valid high and
// cannot be held off. An insert walks every level and allocates a node at each
// level whose child link is empty. A query walks every level and also reads
// the opposite child at each level where that child exists. A delete of a
// present key makes a check walk then an update walk, and ends the check walk
// early when the key is absent. An insert refused for a nearly full pool and an
// unused op go straight to the result. An insert refused for a full root count
// and a query on an empty set end after the root read. o_valid rises in the same
// cycle that busy falls. Each trie level costs a read of the node memory
// (registered read port) plus a write or decision step. After reset a clearing
// pass writes the root node once before start is taken. Nodes are never freed;
// inserts are refused with fewer than KEY_BITS free nodes left.
`include "assert_macros.svh"
module max_xor_multiset_trie #(
    parameter int NODE_COUNT = mxt_pkg::NodeCountDef,
    parameter int KEY_BITS   = mxt_pkg::KeyBitsDef,
    parameter int COUNT_BITS = mxt_pkg::CountBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_op,
    input  logic [31:0] i_key,
    output logic        o_valid,
    output logic [31:0] o_max_xor,
    output logic [1:0]  o_status
);
    import mxt_pkg::*;

    localparam int AW = $clog2(NODE_COUNT);
    localparam int LW = $clog2(KEY_BITS);
    localparam logic [AW:0] NODES = (AW+1)'(NODE_COUNT);
    localparam logic [AW:0] KBW   = (AW+1)'(KEY_BITS);
    localparam logic [COUNT_BITS-1:0] CMAX = '1;

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001, S_IDLE = 7'b0000010, S_RD = 7'b0000100,
        S_EX = 7'b0001000, S_CHK = 7'b0010000, S_UPD = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_st, n_st;
    logic [1:0]          r_op, n_op;
    logic [KEY_BITS-1:0] r_key, n_key;
    logic [AW-1:0]       r_cur, n_cur;
    logic [LW-1:0]       r_lvl, n_lvl;
    logic                r_last, n_last;   // walked past the leaf level
    logic                r_pass2, n_pass2; // delete update walk
    logic [AW:0]         r_free, n_free;
    logic [31:0]         r_ans, n_ans;
    logic [1:0]          r_stat, n_stat;
    logic                r_val;
    logic                r_qalt, n_qalt;   // query: reading the opposite child

    logic [AW-1:0]       m_raddr, m_waddr, m_wc0, m_wc1, m_c0, m_c1;
    logic [COUNT_BITS-1:0] m_wcnt, m_cnt;
    logic                m_we;
    logic [AW-1:0]       r_c0, r_c1;      // parent links held for query fallback

    mxt_node_mem #(.AW(AW), .CW(COUNT_BITS)) u_mem (
        .i_clk(i_clk), .i_raddr(m_raddr), .o_c0(m_c0), .o_c1(m_c1), .o_cnt(m_cnt),
        .i_we(m_we), .i_waddr(m_waddr), .i_wc0(m_wc0), .i_wc1(m_wc1), .i_wcnt(m_wcnt)
    );

    logic kb;
    logic [AW-1:0] nx;
    assign kb = r_key[r_lvl];

    // sequencer: read a node, then act on it and pick the next one
    always_comb begin
        n_st = r_st; n_op = r_op; n_key = r_key; n_cur = r_cur; n_lvl = r_lvl;
        n_last = r_last; n_pass2 = r_pass2; n_free = r_free; n_ans = r_ans;
        n_stat = r_stat; n_qalt = r_qalt;
        m_raddr = r_cur; m_we = 1'b0; m_waddr = r_cur;
        m_wc0 = m_c0; m_wc1 = m_c1; m_wcnt = m_cnt;
        nx = kb ? m_c1 : m_c0;
        case (r_st)
            S_INIT: begin
                m_we = 1'b1; m_waddr = '0; m_wc0 = '0; m_wc1 = '0; m_wcnt = '0;
                n_st = S_IDLE;
            end
            S_IDLE: begin
                if (start) begin
                    n_op = i_op; n_key = i_key[KEY_BITS-1:0]; n_cur = '0;
                    n_lvl = LW'(KEY_BITS-1); n_last = 1'b0; n_pass2 = 1'b0;
                    n_ans = '0; n_stat = ST_OK; n_qalt = 1'b0;
                    n_st = (i_op inside {OP_INS, OP_DEL, OP_QRY}) ? S_RD : S_DONE;
                    if (i_op == OP_INS && (NODES - r_free) < KBW) begin
                        n_stat = ST_FULL; n_st = S_DONE;
                    end
                end
            end
            S_RD: n_st = (r_op == OP_DEL && !r_pass2) ? S_CHK
                       : (r_op == OP_QRY) ? S_EX : S_UPD;
            S_UPD: begin
                // insert or delete-update: adjust count, maybe allocate a child
                if (r_op == OP_INS) begin
                    if (r_cur == '0 && m_cnt == CMAX) begin
                        n_stat = ST_FULL; n_st = S_DONE;
                    end else begin
                        m_we = 1'b1; m_wcnt = m_cnt + 1'b1;
                        n_st = S_RD;
                        if (r_last) begin
                            n_st = S_DONE;
                        end else if (nx == '0) begin
                            if (kb) m_wc1 = r_free[AW-1:0];
                            else    m_wc0 = r_free[AW-1:0];
                            n_free = r_free + 1'b1;
                            n_cur = r_free[AW-1:0];
                            n_st = S_EX; // fresh node: write it empty first
                        end else begin
                            n_cur = nx;
                        end
                    end
                end else begin
                    m_we = 1'b1; m_wcnt = m_cnt - 1'b1;
                    n_cur = nx; n_st = r_last ? S_DONE : S_RD;
                end
                if (!r_last) begin
                    if (r_lvl == '0) n_last = 1'b1;
                    else n_lvl = r_lvl - 1'b1;
                end
            end
            S_CHK: begin
                // delete check walk; after the leaf, test its count
                if (r_last) begin
                    if (m_cnt == '0) begin
                        n_stat = ST_ABSENT; n_st = S_DONE;
                    end else begin
                        n_pass2 = 1'b1; n_cur = '0; n_last = 1'b0;
                        n_lvl = LW'(KEY_BITS-1); n_st = S_RD;
                    end
                end else if (nx == '0) begin
                    n_stat = ST_ABSENT; n_st = S_DONE;
                end else begin
                    n_cur = nx; n_st = S_RD;
                    if (r_lvl == '0) n_last = 1'b1;
                    else n_lvl = r_lvl - 1'b1;
                end
            end
            S_EX: begin
                if (r_op == OP_INS) begin
                    // initialize the allocated node
                    m_we = 1'b1; m_wc0 = '0; m_wc1 = '0; m_wcnt = '0;
                    n_st = S_RD;
                end else if (!r_qalt) begin
                    // at current node: root empty check, then read opposite child
                    if (r_cur == '0 && r_lvl == LW'(KEY_BITS-1) && !r_last
                        && m_cnt == '0) begin
                        n_stat = ST_EMPTY; n_st = S_DONE;
                    end else if (r_last) begin
                        n_st = S_DONE;
                    end else if ((kb ? m_c0 : m_c1) != '0) begin
                        m_raddr = kb ? m_c0 : m_c1; n_qalt = 1'b1;
                    end else begin
                        n_ans = {r_ans[30:0], 1'b0};
                        if (nx != '0) n_cur = nx;
                        n_st = S_RD;
                        if (r_lvl == '0) n_last = 1'b1;
                        else n_lvl = r_lvl - 1'b1;
                    end
                end else begin
                    // opposite child read: take it if its count is nonzero
                    n_qalt = 1'b0; n_st = S_RD;
                    if (m_cnt != '0) begin
                        n_ans = {r_ans[30:0], 1'b1};
                        n_cur = kb ? r_c0 : r_c1;
                    end else begin
                        n_ans = {r_ans[30:0], 1'b0};
                        if ((kb ? r_c1 : r_c0) != '0) n_cur = kb ? r_c1 : r_c0;
                    end
                    if (r_lvl == '0) n_last = 1'b1;
                    else n_lvl = r_lvl - 1'b1;
                end
            end
            S_DONE: n_st = S_IDLE;
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT; r_free <= (AW+1)'(1); r_val <= 1'b0;
        end else begin
            r_st <= n_st; r_free <= n_free; r_val <= (r_st == S_DONE);
        end
        r_op <= n_op; r_key <= n_key; r_cur <= n_cur; r_lvl <= n_lvl;
        r_last <= n_last; r_pass2 <= n_pass2; r_ans <= n_ans; r_stat <= n_stat;
        r_qalt <= n_qalt;
        if (r_st == S_EX && !r_qalt) begin
            r_c0 <= m_c0; r_c1 <= m_c1;
        end
    end

    assign busy      = (r_st != S_IDLE);
    assign o_valid   = r_val;
    assign o_max_xor = (r_stat == ST_OK && r_op == OP_QRY) ? r_ans : '0;
    assign o_status  = r_stat;

    `AST_IMP(a_free_range, i_clk, i_rst_n, 1'b1, r_free <= NODES, "pool overrun")
    `AST_NXT(a_one_result, i_clk, i_rst_n, o_valid, !o_valid, "double result")
    `AST_NXT(a_busy_after_start, i_clk, i_rst_n, start && !busy, busy, "start lost")
endmodule
